FILE: design/abd_pkg.sv
// Shared types, codes and constants for the autobaud edge interval detector.
package abd_pkg;

    localparam int TIMER_CLOCK_HZ = 32000000;

    localparam int OP_W       = 2;
    localparam int CAPTURE_W  = 16;
    localparam int BUDGET_W   = 16;
    localparam int TIMEOUT_W  = 20;
    localparam int TICKS_W    = TIMEOUT_W - 2;
    localparam int INTERVAL_W = 32;
    localparam int RATE_W     = 20;
    localparam int STATUS_W   = 2;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [BUDGET_W-1:0]  EDGE_BUDGET_RESET = 16'd16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = 20'd1000;

    // Serial divider: dividend is the timer clock, one quotient bit per cycle
    localparam int DIV_W = $clog2(TIMER_CLOCK_HZ + 1);
    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TIMER_CLOCK_HZ);

    localparam int NUM_RATES  = 9;
    localparam int RATE_IDX_W = $clog2(NUM_RATES);

    localparam logic [RATE_W-1:0] STD_RATE [NUM_RATES] = '{
        20'd921600, 20'd460800, 20'd250000, 20'd115200, 20'd57600,
        20'd38400, 20'd19200, 20'd9600, 20'd4800
    };

    // Exclusive +-5% window limits, exact integer floors
    localparam logic [RATE_W-1:0] RATE_HI [NUM_RATES] = '{
        20'(921600 * 105 / 100), 20'(460800 * 105 / 100), 20'(250000 * 105 / 100),
        20'(115200 * 105 / 100), 20'(57600 * 105 / 100), 20'(38400 * 105 / 100),
        20'(19200 * 105 / 100), 20'(9600 * 105 / 100), 20'(4800 * 105 / 100)
    };
    localparam logic [RATE_W-1:0] RATE_LO [NUM_RATES] = '{
        20'(921600 * 95 / 100), 20'(460800 * 95 / 100), 20'(250000 * 95 / 100),
        20'(115200 * 95 / 100), 20'(57600 * 95 / 100), 20'(38400 * 95 / 100),
        20'(19200 * 95 / 100), 20'(9600 * 95 / 100), 20'(4800 * 95 / 100)
    };

    localparam logic [DIV_W-1:0] TOO_FAST_Q =
        DIV_W'((921600 / 100) * 105 + (921600 % 100) * 105 / 100);

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_EDGE  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_ZERO = 2'd1,
        STAT_FAST = 2'd2,
        STAT_NONE = 2'd3
    } status_t;

    // Register select by paddr[2]
    localparam logic REG_EDGE_BUDGET = 1'b0;
    localparam logic REG_TIMEOUT     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SNAP = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

FILE: design/abd_if.sv
// Request channel interfaces for the detector input and result streams.
interface abd_in_if;
    import abd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [CAPTURE_W-1:0] capture_time;

    modport source (output valid, output operation, output capture_time, input ready);
    modport sink   (input valid, input operation, input capture_time, output ready);
endinterface

interface abd_out_if;
    import abd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [RATE_W-1:0]     baud_rate;
    logic [STATUS_W-1:0]   detect_status;
    logic [INTERVAL_W-1:0] shortest_interval;

    modport source (output valid, output baud_rate, output detect_status,
                    output shortest_interval, input ready);
    modport sink   (input valid, input baud_rate, input detect_status,
                    input shortest_interval, output ready);
endinterface

FILE: design/autobaud_edge_interval_detector.sv
// Autobaud detector: edge interval minimum, serial divide and standard-rate snap.
//
// Requests are start, falling edge (with a 16-bit timer capture) and 4 ms tick.
// A request that does not end a run leaves the block idle; one that ends a run
// (edge budget spent, ticks run out, or a start with timeout/4 == 0) then
// occupies the block: a restoring divider yields one quotient bit per cycle,
// then the quotient is checked against one standard rate window per cycle,
// then the result is loaded into the output register once that is free.
// A zero interval skips both steps. The block accepts no request until that
// result is in the output register; it accepts requests while the output
// register still waits to be taken.
// Registers on the APB port: edge_budget at 0x0, timeout at 0x4; both are
// sampled at start.
module autobaud_edge_interval_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    abd_in_if.sink                          in_ch,
    abd_out_if.source                       out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [abd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [abd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [abd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import abd_pkg::*;

    state_t                  state_reg, state_next;
    logic                    measuring_reg, measuring_next;
    logic [INTERVAL_W-1:0]   min_interval_reg, min_interval_next;
    logic [CAPTURE_W-1:0]    last_capture_reg, last_capture_next;
    logic [BUDGET_W-1:0]     edges_left_reg, edges_left_next;
    logic [TICKS_W-1:0]      ticks_left_reg, ticks_left_next;
    logic [BUDGET_W-1:0]     edge_budget_reg;
    logic [TIMEOUT_W-1:0]    timeout_reg;
    logic [INTERVAL_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]        quot_reg, quot_next;
    logic [CNT_W-1:0]        div_cnt_reg, div_cnt_next;
    logic [RATE_IDX_W-1:0]   rate_idx_reg, rate_idx_next;
    logic [RATE_W-1:0]       res_rate_reg, res_rate_next;
    status_t                 res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]       out_rate_reg, out_rate_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [INTERVAL_W-1:0]   out_interval_reg, out_interval_next;

    logic                    in_fire;
    logic                    cfg_write;
    logic                    do_finish;
    logic [CAPTURE_W-1:0]    edge_diff;
    logic [TICKS_W-1:0]      ticks_dec;
    logic [INTERVAL_W:0]     rem_shift;
    logic [INTERVAL_W:0]     rem_diff;
    logic [DIV_W-1:0]        snap_hi;
    logic [DIV_W-1:0]        snap_lo;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_TIMEOUT)
                     ? APB_DATA_W'(timeout_reg) : APB_DATA_W'(edge_budget_reg);

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.baud_rate         = out_rate_reg;
    assign out_ch.detect_status     = out_status_reg;
    assign out_ch.shortest_interval = out_interval_reg;

    assign edge_diff = in_ch.capture_time - last_capture_reg;
    assign ticks_dec = (ticks_left_reg != '0) ? ticks_left_reg - 1'b1 : '0;
    assign rem_shift = {rem_reg, DIVIDEND[div_cnt_reg]};
    assign rem_diff  = rem_shift - {1'b0, min_interval_reg};
    assign snap_hi   = DIV_W'(RATE_HI[rate_idx_reg]);
    assign snap_lo   = DIV_W'(RATE_LO[rate_idx_reg]);

    always_comb
    begin
        state_next        = state_reg;
        measuring_next    = measuring_reg;
        min_interval_next = min_interval_reg;
        last_capture_next = last_capture_reg;
        edges_left_next   = edges_left_reg;
        ticks_left_next   = ticks_left_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        div_cnt_next      = div_cnt_reg;
        rate_idx_next     = rate_idx_reg;
        res_rate_next     = res_rate_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_rate_next     = out_rate_reg;
        out_status_next   = out_status_reg;
        out_interval_next = out_interval_reg;
        do_finish         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.operation == OP_START)
                    begin
                        min_interval_next = '1;
                        last_capture_next = '0;
                        edges_left_next   = edge_budget_reg;
                        ticks_left_next   = timeout_reg[TIMEOUT_W-1:2];
                        measuring_next    = 1'b1;
                        do_finish         = (timeout_reg[TIMEOUT_W-1:2] == '0);
                    end
                    else if (measuring_reg && in_ch.operation == OP_EDGE)
                    begin
                        last_capture_next = in_ch.capture_time;
                        if (INTERVAL_W'(edge_diff) < min_interval_reg)
                            min_interval_next = INTERVAL_W'(edge_diff);
                        if (edges_left_reg == '0)
                            do_finish = 1'b1;
                        else
                            edges_left_next = edges_left_reg - 1'b1;
                    end
                    else if (measuring_reg && in_ch.operation == OP_TICK)
                    begin
                        ticks_left_next = ticks_dec;
                        do_finish       = (ticks_dec == '0);
                    end
                end
                if (do_finish)
                begin
                    measuring_next = 1'b0;
                    if (min_interval_next == '0)
                    begin
                        res_rate_next   = '0;
                        res_status_next = STAT_ZERO;
                        state_next      = ST_FIN;
                    end
                    else
                    begin
                        rem_next     = '0;
                        quot_next    = '0;
                        div_cnt_next = CNT_W'(DIV_W - 1);
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                // restoring step: keep the difference when it does not go negative
                if (!rem_diff[INTERVAL_W])
                    rem_next = rem_diff[INTERVAL_W-1:0];
                else
                    rem_next = rem_shift[INTERVAL_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], !rem_diff[INTERVAL_W]};
                if (div_cnt_reg == '0)
                begin
                    rate_idx_next = '0;
                    state_next    = ST_SNAP;
                end
                else
                    div_cnt_next = div_cnt_reg - 1'b1;
            end
            ST_SNAP:
            begin
                if (rate_idx_reg == '0 && quot_reg > TOO_FAST_Q)
                begin
                    res_rate_next   = '0;
                    res_status_next = STAT_FAST;
                    state_next      = ST_FIN;
                end
                else if (quot_reg < snap_hi && quot_reg > snap_lo)
                begin
                    res_rate_next   = STD_RATE[rate_idx_reg];
                    res_status_next = STAT_OK;
                    state_next      = ST_FIN;
                end
                else if (rate_idx_reg == RATE_IDX_W'(NUM_RATES - 1))
                begin
                    res_rate_next   = '0;
                    res_status_next = STAT_NONE;
                    state_next      = ST_FIN;
                end
                else
                    rate_idx_next = rate_idx_reg + 1'b1;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_rate_next     = res_rate_reg;
                    out_status_next   = res_status_reg;
                    out_interval_next = min_interval_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            measuring_reg    <= 1'b0;
            min_interval_reg <= '1;
            last_capture_reg <= '0;
            edges_left_reg   <= '0;
            ticks_left_reg   <= '0;
            edge_budget_reg  <= EDGE_BUDGET_RESET;
            timeout_reg      <= TIMEOUT_RESET;
            rem_reg          <= '0;
            quot_reg         <= '0;
            div_cnt_reg      <= '0;
            rate_idx_reg     <= '0;
            res_rate_reg     <= '0;
            res_status_reg   <= STAT_NONE;
            out_valid_reg    <= 1'b0;
            out_rate_reg     <= '0;
            out_status_reg   <= '0;
            out_interval_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            measuring_reg    <= measuring_next;
            min_interval_reg <= min_interval_next;
            last_capture_reg <= last_capture_next;
            edges_left_reg   <= edges_left_next;
            ticks_left_reg   <= ticks_left_next;
            rem_reg          <= rem_next;
            quot_reg         <= quot_next;
            div_cnt_reg      <= div_cnt_next;
            rate_idx_reg     <= rate_idx_next;
            res_rate_reg     <= res_rate_next;
            res_status_reg   <= res_status_next;
            out_valid_reg    <= out_valid_next;
            out_rate_reg     <= out_rate_next;
            out_status_reg   <= out_status_next;
            out_interval_reg <= out_interval_next;
            if (cfg_write)
            begin
                if (paddr[2] == REG_EDGE_BUDGET)
                    edge_budget_reg <= pwdata[BUDGET_W-1:0];
                else
                    timeout_reg <= pwdata[TIMEOUT_W-1:0];
            end
        end
    end

endmodule
